[sv/kbtlv_pkg.sv]
`default_nettype none

package kbtlv_pkg;

  localparam int MAX_KEYS          = 20;
  localparam int WRAPPED_KEY_BYTES = 40;
  localparam int SALT_BYTES        = 20;
  localparam int UUID_BYTES        = 16;

  localparam int BLOB_LEN_W = 20;
  localparam int KIND_W     = 4;
  localparam int VALUE_W    = 32;
  localparam int SLOT_W     = 5;
  localparam int OFFSET_W   = 6;
  localparam int CAP_W      = 7;

  // Bundle queue depth; must be a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] TAG_DATA = 32'h41544144;
  localparam logic [31:0] TAG_VERS = 32'h53524556;
  localparam logic [31:0] TAG_TYPE = 32'h45505954;
  localparam logic [31:0] TAG_SALT = 32'h544C4153;
  localparam logic [31:0] TAG_ITER = 32'h52455449;
  localparam logic [31:0] TAG_UUID = 32'h44495555;
  localparam logic [31:0] TAG_CLAS = 32'h53414C43;
  localparam logic [31:0] TAG_WRAP = 32'h50415257;
  localparam logic [31:0] TAG_WPKY = 32'h594B5057;

  localparam logic ADDR_BLOB_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    PH_OUTER_TAG,
    PH_OUTER_LEN,
    PH_REC_TAG,
    PH_REC_LEN,
    PH_REC_DATA,
    PH_STOP
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_VERSION    = 4'd0,
    KIND_TYPE       = 4'd1,
    KIND_ITER       = 4'd2,
    KIND_SALT       = 4'd3,
    KIND_BAG_UUID   = 4'd4,
    KIND_KEY_UUID   = 4'd5,
    KIND_CLASS      = 4'd6,
    KIND_WRAP       = 4'd7,
    KIND_WPKY       = 4'd8,
    KIND_DONE       = 4'd9,
    KIND_BAD_MAGIC  = 4'd10,
    KIND_BAD_LENGTH = 4'd11,
    KIND_KEY_LIMIT  = 4'd12,
    KIND_NONE       = 4'd15
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
  } item_t;

  typedef struct packed {
    logic  two;
    item_t first;
    item_t second;
  } bundle_t;

endpackage

`default_nettype wire

[sv/keybag_tlv_parser_top.sv]
// Key-bag tag-length-value parser.
// Input channel: push/full with data_byte and first_byte; a byte is taken at
// a clock edge with push high and full low. first_byte restarts parsing.
// Result channel: empty/pop; the oldest result sits on item_kind, item_value,
// key_slot, byte_offset and last_of_run while empty is low, and is taken at
// an edge with pop high.
// Configuration: APB write of blob_length at address 0, pready tied high.
// Throughput: one byte per cycle while full is low. A byte gives zero, one
// or two results, registered together into the queue; a second one follows
// on the next pop. The parser runs one step per byte; a four-entry bundle
// queue separates it from the result side, so full rises only after the
// receiver has stalled long enough to fill it.
// Reset clears the parser, the queue and blob_length; results still queued
// are dropped.
`default_nettype none

module keybag_tlv_parser_top
  import kbtlv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  first_byte,
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [KIND_W-1:0]     item_kind,
  output logic      [VALUE_W-1:0]    item_value,
  output logic      [SLOT_W-1:0]     key_slot,
  output logic      [OFFSET_W-1:0]   byte_offset,
  output logic                       last_of_run
);

  logic [BLOB_LEN_W-1:0] blob_length;
  logic                  accept;
  logic                  bundle_valid;
  bundle_t               bundle;
  bundle_t               head;
  logic                  q_empty;
  logic                  q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_BLOB_LENGTH) ? 32'(blob_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blob_length <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_BLOB_LENGTH) begin
      blob_length <= pwdata[BLOB_LEN_W-1:0];
    end
  end

  assign accept = push && !full;

  kbtlv_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .blob_length  (blob_length),
    .bundle_valid (bundle_valid),
    .bundle       (bundle)
  );

  kbtlv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (bundle_valid),
    .wr_data (bundle),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (head),
    .empty   (q_empty)
  );

  kbtlv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .item_kind   (item_kind),
    .item_value  (item_value),
    .key_slot    (key_slot),
    .byte_offset (byte_offset),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

[sv/kbtlv_front.sv]
`default_nettype none

module kbtlv_front
  import kbtlv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  first_byte,
  input  wire logic [BLOB_LEN_W-1:0] blob_length,
  output logic                       bundle_valid,
  output bundle_t                    bundle
);

  phase_t                phase, phase_next, cur_phase;
  logic [BLOB_LEN_W-1:0] fbc, fbc_next, cur_fbc;
  logic [BLOB_LEN_W-1:0] bte, bte_next, cur_bte;
  logic [31:0]           tag, tag_next, cur_tag;
  logic [31:0]           rlen, rlen_next, cur_rlen;
  logic [31:0]           acc, acc_next, cur_acc;
  logic                  bag_seen, bag_seen_next, cur_bag_seen;
  logic                  cvalid, cvalid_next, cur_cvalid;
  logic [SLOT_W-1:0]     cidx, cidx_next, cur_cidx;
  kind_t                 rkind, rkind_next, cur_rkind;

  logic [BLOB_LEN_W:0]   fbc_inc;
  logic [31:0]           tag_shift;
  logic [31:0]           rlen_shift;
  logic [SLOT_W:0]       cidx_try;
  logic [2:0]            need;
  logic                  count_byte;
  logic                  item_v;
  item_t                 item;
  logic                  done_v;
  item_t                 done_item;
  kind_t                 okind;

  function automatic logic is_word(input kind_t k);
    return k inside {KIND_VERSION, KIND_TYPE, KIND_ITER, KIND_CLASS, KIND_WRAP};
  endfunction

  function automatic logic [CAP_W-1:0] byte_cap(input kind_t k);
    case (k)
      KIND_SALT:                   return CAP_W'(SALT_BYTES);
      KIND_BAG_UUID, KIND_KEY_UUID: return CAP_W'(UUID_BYTES);
      KIND_WPKY:                   return CAP_W'(WRAPPED_KEY_BYTES);
      default:                     return '0;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] key_count(input logic v, input logic [SLOT_W-1:0] i);
    return v ? VALUE_W'(i) + VALUE_W'(1) : '0;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input kind_t k, input logic v,
                                               input logic [SLOT_W-1:0] i);
    return (k inside {[KIND_KEY_UUID:KIND_WPKY]} && v) ? i : '0;
  endfunction

  // A first byte restarts parsing from the cleared state
  always_comb begin
    if (first_byte) begin
      cur_phase    = PH_OUTER_TAG;
      cur_fbc      = '0;
      cur_bte      = '0;
      cur_tag      = '0;
      cur_rlen     = '0;
      cur_acc      = '0;
      cur_bag_seen = 1'b0;
      cur_cvalid   = 1'b0;
      cur_cidx     = '0;
      cur_rkind    = KIND_NONE;
    end else begin
      cur_phase    = phase;
      cur_fbc      = fbc;
      cur_bte      = bte;
      cur_tag      = tag;
      cur_rlen     = rlen;
      cur_acc      = acc;
      cur_bag_seen = bag_seen;
      cur_cvalid   = cvalid;
      cur_cidx     = cidx;
      cur_rkind    = rkind;
    end
  end

  always_comb begin
    phase_next    = cur_phase;
    fbc_next      = cur_fbc;
    bte_next      = cur_bte;
    tag_next      = cur_tag;
    rlen_next     = cur_rlen;
    acc_next      = cur_acc;
    bag_seen_next = cur_bag_seen;
    cvalid_next   = cur_cvalid;
    cidx_next     = cur_cidx;
    rkind_next    = cur_rkind;
    count_byte    = 1'b0;
    item_v        = 1'b0;
    item          = '{kind: KIND_NONE, value: '0, slot: '0, offset: '0};
    done_v        = 1'b0;
    done_item     = '{kind: KIND_DONE, value: '0, slot: '0, offset: '0};
    okind         = KIND_NONE;
    cidx_try      = '0;
    need          = '0;

    fbc_inc    = {1'b0, cur_fbc} + (BLOB_LEN_W+1)'(1);
    tag_shift  = {data_byte, cur_tag[31:8]};
    rlen_shift = {cur_rlen[23:0], data_byte};

    case (cur_phase)
      PH_OUTER_TAG, PH_REC_TAG: begin
        tag_next   = tag_shift;
        fbc_next   = fbc_inc[BLOB_LEN_W-1:0];
        count_byte = (cur_phase == PH_REC_TAG);
        if (cur_fbc[1:0] == 2'd3) begin
          fbc_next  = '0;
          rlen_next = '0;
          if (cur_phase == PH_REC_TAG) begin
            phase_next = PH_REC_LEN;
          end else if (tag_shift != TAG_DATA) begin
            item_v     = 1'b1;
            item.kind  = KIND_BAD_MAGIC;
            phase_next = PH_STOP;
          end else begin
            phase_next = PH_OUTER_LEN;
          end
        end
      end
      PH_OUTER_LEN: begin
        rlen_next = rlen_shift;
        fbc_next  = fbc_inc[BLOB_LEN_W-1:0];
        if (cur_fbc[1:0] == 2'd3) begin
          fbc_next = '0;
          if ({1'b0, rlen_shift} + 33'd8 > 33'(blob_length)) begin
            item_v     = 1'b1;
            item.kind  = KIND_BAD_LENGTH;
            phase_next = PH_STOP;
          end else if (rlen_shift == '0) begin
            item_v     = 1'b1;
            item.kind  = KIND_DONE;
            item.value = key_count(cur_cvalid, cur_cidx);
            phase_next = PH_STOP;
          end else begin
            bte_next   = rlen_shift[BLOB_LEN_W-1:0];
            tag_next   = '0;
            phase_next = PH_REC_TAG;
          end
        end
      end
      PH_REC_LEN: begin
        count_byte = 1'b1;
        rlen_next  = rlen_shift;
        fbc_next   = fbc_inc[BLOB_LEN_W-1:0];
        if (cur_fbc[1:0] == 2'd3) begin
          fbc_next = '0;
          acc_next = '0;
          cidx_try = cur_cvalid ? {1'b0, cur_cidx} + (SLOT_W+1)'(1) : '0;
          // Classify the record on its tag
          case (cur_tag)
            TAG_VERS: okind = KIND_VERSION;
            TAG_TYPE: okind = KIND_TYPE;
            TAG_ITER: okind = KIND_ITER;
            TAG_SALT: okind = KIND_SALT;
            TAG_UUID: begin
              if (!cur_bag_seen) begin
                bag_seen_next = 1'b1;
                okind         = KIND_BAG_UUID;
              end else if (cidx_try < (SLOT_W+1)'(MAX_KEYS)) begin
                cvalid_next = 1'b1;
                cidx_next   = cidx_try[SLOT_W-1:0];
                okind       = KIND_KEY_UUID;
              end else begin
                okind = KIND_KEY_LIMIT;
              end
            end
            TAG_CLAS: okind = cur_cvalid ? KIND_CLASS : KIND_NONE;
            TAG_WRAP: okind = cur_cvalid ? KIND_WRAP : KIND_NONE;
            TAG_WPKY: okind = cur_cvalid ? KIND_WPKY : KIND_NONE;
            default:  okind = KIND_NONE;
          endcase
          if (okind == KIND_KEY_LIMIT) begin
            rkind_next = KIND_NONE;
            item_v     = 1'b1;
            item.kind  = KIND_KEY_LIMIT;
            item.value = VALUE_W'(MAX_KEYS);
            phase_next = PH_STOP;
            count_byte = 1'b0;
          end else begin
            rkind_next = okind;
            if (rlen_shift == '0) begin
              if (is_word(okind)) begin
                item_v    = 1'b1;
                item.kind = okind;
                item.slot = slot_of(okind, cvalid_next, cidx_next);
              end
              tag_next   = '0;
              phase_next = PH_REC_TAG;
            end else begin
              phase_next = PH_REC_DATA;
            end
          end
        end
      end
      PH_REC_DATA: begin
        count_byte = 1'b1;
        if (is_word(cur_rkind)) begin
          if (cur_fbc[BLOB_LEN_W-1:2] == '0) begin
            case (cur_fbc[1:0])
              2'd0:    acc_next = cur_acc | {data_byte, 24'h0};
              2'd1:    acc_next = cur_acc | {8'h0, data_byte, 16'h0};
              2'd2:    acc_next = cur_acc | {16'h0, data_byte, 8'h0};
              default: acc_next = cur_acc | {24'h0, data_byte};
            endcase
          end
          need = (cur_rlen < 32'd4) ? cur_rlen[2:0] : 3'd4;
          if (fbc_inc == (BLOB_LEN_W+1)'(need)) begin
            item_v     = 1'b1;
            item.kind  = cur_rkind;
            item.value = acc_next;
            item.slot  = slot_of(cur_rkind, cur_cvalid, cur_cidx);
          end
        end else if (cur_rkind != KIND_NONE &&
                     cur_fbc < BLOB_LEN_W'(byte_cap(cur_rkind))) begin
          item_v      = 1'b1;
          item.kind   = cur_rkind;
          item.value  = VALUE_W'(data_byte);
          item.slot   = slot_of(cur_rkind, cur_cvalid, cur_cidx);
          item.offset = cur_fbc[OFFSET_W-1:0];
        end
        fbc_next = fbc_inc[BLOB_LEN_W-1:0];
        if (32'(fbc_inc) == cur_rlen) begin
          fbc_next   = '0;
          tag_next   = '0;
          phase_next = PH_REC_TAG;
        end
      end
      default: begin
      end
    endcase

    // Count down the outer length; done when it runs out
    if (count_byte && cur_bte != '0) begin
      bte_next = cur_bte - BLOB_LEN_W'(1);
      if (cur_bte == BLOB_LEN_W'(1)) begin
        done_v          = 1'b1;
        done_item.value = key_count(cvalid_next, cidx_next);
        phase_next      = PH_STOP;
      end
    end

    bundle_valid = accept && (item_v || done_v);
    if (item_v) begin
      bundle.two    = done_v;
      bundle.first  = item;
      bundle.second = done_item;
    end else begin
      bundle.two    = 1'b0;
      bundle.first  = done_item;
      bundle.second = done_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_OUTER_TAG;
      fbc      <= '0;
      bte      <= '0;
      tag      <= '0;
      rlen     <= '0;
      acc      <= '0;
      bag_seen <= 1'b0;
      cvalid   <= 1'b0;
      cidx     <= '0;
      rkind    <= KIND_NONE;
    end else if (accept) begin
      phase    <= phase_next;
      fbc      <= fbc_next;
      bte      <= bte_next;
      tag      <= tag_next;
      rlen     <= rlen_next;
      acc      <= acc_next;
      bag_seen <= bag_seen_next;
      cvalid   <= cvalid_next;
      cidx     <= cidx_next;
      rkind    <= rkind_next;
    end
  end

  a_stop_silent: assert property (@(posedge clk) disable iff (rst)
    accept && !first_byte && phase == PH_STOP |-> !bundle_valid)
    else $error("bundle produced while parsing is stopped");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    cvalid |-> 6'(cidx) < 6'(MAX_KEYS))
    else $error("class index beyond key limit");

  a_second_is_done: assert property (@(posedge clk) disable iff (rst)
    bundle_valid && bundle.two |-> bundle.second.kind == KIND_DONE)
    else $error("second result of a byte is not done");

  a_final_stops: assert property (@(posedge clk) disable iff (rst)
    bundle_valid && (bundle.two || bundle.first.kind == KIND_DONE ||
                     bundle.first.kind == KIND_BAD_MAGIC ||
                     bundle.first.kind == KIND_BAD_LENGTH ||
                     bundle.first.kind == KIND_KEY_LIMIT)
    |=> phase == PH_STOP)
    else $error("parser kept running after a final result");

endmodule

`default_nettype wire

[sv/kbtlv_queue.sv]
`default_nettype none

module kbtlv_queue
  import kbtlv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    wr_en,
  input  wire bundle_t wr_data,
  output logic         full,
  input  wire logic    rd_en,
  output bundle_t      rd_data,
  output logic         empty
);

  bundle_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + QUEUE_AW'(1);
      end
      if (do_rd) begin
        rptr <= rptr + QUEUE_AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/kbtlv_back.sv]
`default_nettype none

module kbtlv_back
  import kbtlv_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bundle_t        head,
  input  wire logic           q_empty,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output logic [KIND_W-1:0]   item_kind,
  output logic [VALUE_W-1:0]  item_value,
  output logic [SLOT_W-1:0]   key_slot,
  output logic [OFFSET_W-1:0] byte_offset,
  output logic                last_of_run
);

  logic  sel;
  logic  sel_next;
  item_t cur;

  assign empty       = q_empty;
  assign cur         = sel ? head.second : head.first;
  assign item_kind   = cur.kind;
  assign item_value  = cur.value;
  assign key_slot    = cur.slot;
  assign byte_offset = cur.offset;
  assign last_of_run = sel || !head.two;

  // Release the bundle once its last result is taken
  assign q_pop = pop && !q_empty && last_of_run;

  always_comb begin
    sel_next = sel;
    if (pop && !q_empty) begin
      sel_next = !sel && head.two;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else begin
      sel <= sel_next;
    end
  end

  a_sel_valid: assert property (@(posedge clk) disable iff (rst)
    sel |-> !q_empty && head.two)
    else $error("second result selected without a two-result bundle");

endmodule

`default_nettype wire

[tb/kbtlv_result_checker.sv]
module kbtlv_result_checker
  import kbtlv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  input  logic                push,
  input  logic                full,
  input  logic [7:0]          data_byte,
  input  logic                first_byte,
  input  logic                pop,
  input  logic                empty,
  input  logic [KIND_W-1:0]   item_kind,
  input  logic [VALUE_W-1:0]  item_value,
  input  logic [SLOT_W-1:0]   key_slot,
  input  logic [OFFSET_W-1:0] byte_offset,
  input  logic                last_of_run,
  output int                  mismatches,
  output int                  awaited
);

  localparam logic [5:0] NO_CLASS = 6'd63;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  value;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
    logic                last;
  } result_t;

  // Parser copy
  logic [BLOB_LEN_W-1:0] blob_len;
  phase_t                phase;
  logic [31:0]           fcount;
  logic [31:0]           remaining;
  logic [31:0]           tag_acc;
  logic [31:0]           rec_len;
  logic [31:0]           word_acc;
  logic                  bag_seen;
  logic [5:0]            cls;
  kind_t                 rkind;

  result_t pending_items[$];
  result_t run_buf [2];
  int      run_n;

  function automatic logic is_word(kind_t k);
    return k inside {KIND_VERSION, KIND_TYPE, KIND_ITER, KIND_CLASS, KIND_WRAP};
  endfunction

  function automatic logic [SLOT_W-1:0] slot_for(kind_t k);
    if (k inside {KIND_KEY_UUID, KIND_CLASS, KIND_WRAP, KIND_WPKY} && cls != NO_CLASS) begin
      return cls[SLOT_W-1:0];
    end
    return '0;
  endfunction

  function automatic logic [31:0] keys_seen();
    return (cls == NO_CLASS) ? 32'd0 : 32'(cls) + 32'd1;
  endfunction

  task automatic emit(input logic [KIND_W-1:0] k, input logic [31:0] v,
                      input logic [SLOT_W-1:0] s, input logic [OFFSET_W-1:0] o);
    run_buf[run_n] = {k, v, s, o, 1'b0};
    run_n++;
  endtask

  task automatic restart_parse();
    phase     = PH_OUTER_TAG;
    fcount    = '0;
    remaining = '0;
    tag_acc   = '0;
    rec_len   = '0;
    word_acc  = '0;
    bag_seen  = 1'b0;
    cls       = NO_CLASS;
    rkind     = KIND_NONE;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic first);
    logic        counted;
    logic [31:0] need;
    logic [31:0] next_cls;
    logic [31:0] cap;
    result_t     r;
    counted = 1'b1;
    run_n   = 0;
    if (first) restart_parse();
    case (phase)
      PH_OUTER_TAG, PH_REC_TAG: begin
        tag_acc = tag_acc | ({24'd0, b} << (8 * fcount[1:0]));
        fcount++;
        if (fcount == 4) begin
          fcount = '0;
          if (phase == PH_REC_TAG) begin
            phase = PH_REC_LEN;
          end else if (tag_acc == TAG_DATA) begin
            phase = PH_OUTER_LEN;
          end else begin
            emit(KIND_BAD_MAGIC, '0, '0, '0);
            phase = PH_STOP;
          end
          rec_len = '0;
        end
        // header bytes never count toward the outer length
        if (phase inside {PH_OUTER_TAG, PH_OUTER_LEN, PH_STOP}) counted = 1'b0;
      end
      PH_OUTER_LEN: begin
        counted = 1'b0;
        rec_len = {rec_len[23:0], b};
        fcount++;
        if (fcount == 4) begin
          fcount = '0;
          if ({1'b0, rec_len} + 33'd8 > 33'(blob_len)) begin
            emit(KIND_BAD_LENGTH, '0, '0, '0);
            phase = PH_STOP;
          end else if (rec_len == 0) begin
            emit(KIND_DONE, keys_seen(), '0, '0);
            phase = PH_STOP;
          end else begin
            remaining = rec_len;
            tag_acc   = '0;
            phase     = PH_REC_TAG;
          end
        end
      end
      PH_REC_LEN: begin
        rec_len = {rec_len[23:0], b};
        fcount++;
        if (fcount == 4) begin
          fcount   = '0;
          word_acc = '0;
          rkind    = KIND_NONE;
          next_cls = (cls == NO_CLASS) ? 32'd0 : 32'(cls) + 32'd1;
          case (tag_acc)
            TAG_VERS: rkind = KIND_VERSION;
            TAG_TYPE: rkind = KIND_TYPE;
            TAG_ITER: rkind = KIND_ITER;
            TAG_SALT: rkind = KIND_SALT;
            TAG_UUID: begin
              // first uuid belongs to the bag, later ones open class keys
              if (!bag_seen) begin
                bag_seen = 1'b1;
                rkind    = KIND_BAG_UUID;
              end else if (next_cls < MAX_KEYS) begin
                cls   = next_cls[5:0];
                rkind = KIND_KEY_UUID;
              end else begin
                emit(KIND_KEY_LIMIT, 32'(MAX_KEYS), '0, '0);
                phase   = PH_STOP;
                counted = 1'b0;
              end
            end
            TAG_CLAS: if (cls != NO_CLASS) rkind = KIND_CLASS;
            TAG_WRAP: if (cls != NO_CLASS) rkind = KIND_WRAP;
            TAG_WPKY: if (cls != NO_CLASS) rkind = KIND_WPKY;
            default: ;
          endcase
          if (phase != PH_STOP) begin
            if (rec_len == 0) begin
              if (is_word(rkind)) emit(rkind, '0, slot_for(rkind), '0);
              tag_acc = '0;
              phase   = PH_REC_TAG;
            end else begin
              phase = PH_REC_DATA;
            end
          end
        end
      end
      PH_REC_DATA: begin
        if (is_word(rkind)) begin
          need = (rec_len < 4) ? rec_len : 32'd4;
          if (fcount < 4) word_acc = word_acc | ({24'd0, b} << (24 - 8 * fcount[1:0]));
          if (fcount + 1 == need) emit(rkind, word_acc, slot_for(rkind), '0);
        end else if (rkind != KIND_NONE) begin
          case (rkind)
            KIND_SALT:                   cap = SALT_BYTES;
            KIND_BAG_UUID, KIND_KEY_UUID: cap = UUID_BYTES;
            KIND_WPKY:                   cap = WRAPPED_KEY_BYTES;
            default:                     cap = 0;
          endcase
          if (fcount < cap) emit(rkind, {24'd0, b}, slot_for(rkind), fcount[OFFSET_W-1:0]);
        end
        fcount++;
        if (fcount == rec_len) begin
          fcount  = '0;
          tag_acc = '0;
          phase   = PH_REC_TAG;
        end
      end
      default: counted = 1'b0;
    endcase

    if (counted && remaining != 0) begin
      remaining--;
      if (remaining == 0) begin
        emit(KIND_DONE, keys_seen(), '0, '0);
        phase = PH_STOP;
      end
    end

    for (int i = 0; i < run_n; i++) begin
      r      = run_buf[i];
      r.last = (i == run_n - 1);
      pending_items.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      blob_len = '0;
      restart_parse();
      pending_items.delete();
      mismatches = 0;
    end else begin
      if (pop && !empty) begin
        if (pending_items.size() == 0) begin
          $error("result with nothing pending: item_kind %0d item_value 0x%08h",
                 item_kind, item_value);
          mismatches++;
        end else begin
          want = pending_items.pop_front();
          if (item_kind !== want.kind) begin
            $error("item_kind: expected %0d, got %0d", want.kind, item_kind);
            mismatches++;
          end
          if (item_value !== want.value) begin
            $error("item_value: expected 0x%08h, got 0x%08h", want.value, item_value);
            mismatches++;
          end
          if (key_slot !== want.slot) begin
            $error("key_slot: expected %0d, got %0d", want.slot, key_slot);
            mismatches++;
          end
          if (byte_offset !== want.offset) begin
            $error("byte_offset: expected %0d, got %0d", want.offset, byte_offset);
            mismatches++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
            mismatches++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == {ADDR_BLOB_LENGTH, 2'b00}) begin
        blob_len = pwdata[BLOB_LEN_W-1:0];
      end
      if (push && !full) decode_byte(data_byte, first_byte);
    end
    awaited = pending_items.size();
  end

endmodule

[tb/keybag_tlv_parser_top_tb.sv]
module keybag_tlv_parser_top_tb;
  import kbtlv_pkg::*;

  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_BYTES   = 400;
  localparam logic [BLOB_LEN_W-1:0] BLOB_LEN_MAX = '1;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                push;
  logic                full;
  logic [7:0]          data_byte;
  logic                first_byte;
  logic                empty;
  logic                pop;
  logic [KIND_W-1:0]   item_kind;
  logic [VALUE_W-1:0]  item_value;
  logic [SLOT_W-1:0]   key_slot;
  logic [OFFSET_W-1:0] byte_offset;
  logic                last_of_run;

  int mismatches;
  int awaited;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_count;
  int bytes_sent;
  bit hold_request;

  logic [BLOB_LEN_W-1:0] blob_length_now;
  logic [7:0]            blob[$];
  logic [7:0]            body[$];
  logic [31:0]           known_tags [9] = '{TAG_VERS, TAG_TYPE, TAG_ITER, TAG_SALT, TAG_UUID,
                                            TAG_CLAS, TAG_WRAP, TAG_WPKY, TAG_DATA};

  keybag_tlv_parser_top DUT (.*);

  kbtlv_result_checker result_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_count <= 0;
    end else if (stall_count >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push       <= 1'b1;
    data_byte  <= b;
    first_byte <= first;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_blob();
    foreach (blob[i]) begin
      send_byte(blob[i], i == 0);
      bytes_sent++;
    end
  endtask

  // Drop push and wait for every pending result plus the pipeline tail
  task automatic settle();
    push <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_blob_length(input logic [BLOB_LEN_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ADDR_BLOB_LENGTH, 2'b00};
    pwdata  <= {12'($urandom()), v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    blob_length_now = v;
  endtask

  task automatic put_tag(input logic [31:0] tag);
    for (int i = 0; i < 4; i++) blob.push_back(tag[8*i +: 8]);
  endtask

  task automatic put_be(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) blob.push_back(w[8*i +: 8]);
  endtask

  task automatic put_header(input logic [31:0] tag, input logic [31:0] outer);
    put_tag(tag);
    put_be(outer);
  endtask

  task automatic put_record(input logic [31:0] tag, input int len);
    put_tag(tag);
    put_be(32'(len));
    repeat (len) blob.push_back(8'($urandom_range(255)));
  endtask

  function automatic int word_len();
    return ($urandom_range(3) != 0) ? 4 : $urandom_range(0, 6);
  endfunction

  function automatic int field_len(input int nominal);
    return ($urandom_range(9) < 6) ? nominal : $urandom_range(0, nominal + 4);
  endfunction

  task automatic build_blob();
    int          nkeys;
    int          body_len;
    int          pick;
    int          keep;
    bit          crowd;
    logic [31:0] magic;
    logic [31:0] outer;
    blob.delete();
    if ($urandom_range(99) < 85) begin
      if ($urandom_range(3) != 0) put_record(TAG_VERS, word_len());
      if ($urandom_range(3) != 0) put_record(TAG_TYPE, word_len());
      // class field ahead of any class key
      if ($urandom_range(5) == 0) put_record(known_tags[$urandom_range(5, 7)], word_len());
      put_record(TAG_UUID, field_len(UUID_BYTES));
      put_record(TAG_SALT, field_len(SALT_BYTES));
      if ($urandom_range(4) == 0) put_record(TAG_SALT, field_len(SALT_BYTES));
      put_record(TAG_ITER, word_len());
      crowd = ($urandom_range(3) == 0);
      nkeys = crowd ? $urandom_range(MAX_KEYS - 1, MAX_KEYS + 2) : $urandom_range(0, 2);
      for (int k = 0; k < nkeys; k++) begin
        if (crowd) begin
          put_record(TAG_UUID, $urandom_range(0, 2));
        end else begin
          put_record(TAG_UUID, field_len(UUID_BYTES));
          put_record(TAG_CLAS, word_len());
          put_record(TAG_WRAP, word_len());
          put_record(TAG_WPKY, field_len(WRAPPED_KEY_BYTES));
        end
        if ($urandom_range(7) == 0) put_record($urandom(), $urandom_range(0, 6));
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        put_record(($urandom_range(9) == 9) ? $urandom() : known_tags[$urandom_range(0, 8)],
                   $urandom_range(0, 24));
      end
    end

    body.delete();
    foreach (blob[i]) body.push_back(blob[i]);
    blob.delete();
    body_len = body.size();

    magic = ($urandom_range(19) == 0) ? $urandom() : TAG_DATA;
    pick  = $urandom_range(99);
    if (pick < 70) outer = 32'(body_len);
    else if (pick < 82) outer = 32'($urandom_range(0, body_len));
    else if (pick < 92) outer = 32'(body_len + $urandom_range(1, 6));
    else outer = $urandom();
    put_header(magic, outer);

    // trim bytes that would only be ignored once parsing stops
    if (magic != TAG_DATA || {1'b0, outer} + 33'd8 > 33'(blob_length_now)) begin
      keep = $urandom_range(0, 4);
    end else if (outer < body_len) begin
      keep = int'(outer) + $urandom_range(0, 3);
    end else begin
      keep = body_len;
    end
    if ($urandom_range(15) == 0) keep = $urandom_range(0, keep);
    for (int i = 0; i < keep && i < body_len; i++) blob.push_back(body[i]);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [BLOB_LEN_W-1:0] blen, input bit squeeze);
    int goal;
    settle();
    write_blob_length(blen);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (squeeze) hold_request = 1'b1;
    goal = bytes_sent + PHASE_BYTES;
    while (bytes_sent < goal) begin
      build_blob();
      send_blob();
    end
  endtask

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    push            = 1'b0;
    data_byte       = '0;
    first_byte      = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    hold_request    = 1'b0;
    bytes_sent      = 0;
    blob_length_now = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // blob_length still at its reset value: any header is too long
    blob.delete();
    put_header(TAG_DATA, '0);
    send_blob();
    settle();
    write_blob_length(BLOB_LEN_MAX);

    // bad magic, then a byte while stopped
    blob.delete();
    put_tag(32'h00FF00FF);
    blob.push_back(8'hA5);
    send_blob();

    // empty outer length
    blob.delete();
    put_header(TAG_DATA, '0);
    send_blob();

    run_phase(15, 62, BLOB_LEN_W'($urandom_range(64, 1500)), 1'b0);
    run_phase(62, 15, BLOB_LEN_W'($urandom_range(600, 8000)), 1'b0);
    run_phase(0, 0, BLOB_LEN_MAX, 1'b1);
    settle();

    if (mismatches == 0 && awaited == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/kbtlv_pkg.sv
sv/kbtlv_front.sv
sv/kbtlv_queue.sv
sv/kbtlv_back.sv
sv/keybag_tlv_parser_top.sv
tb/kbtlv_result_checker.sv
tb/keybag_tlv_parser_top_tb.sv
